@@ rtl/assert_macros.svh @@
// Assertion macros for the RTL. Bodies vanish in synthesis builds.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Checked on every rising edge of clk, ignored while rst is high
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every rising edge of clk, reset included
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_CLK_ALWAYS(label, prop, msg)
`endif

`endif

@@ rtl/ubsd_pkg.sv @@
package ubsd_pkg;

  // Encoding register codes
  localparam logic [1:0] ENC_UTF8    = 2'd0;
  localparam logic [1:0] ENC_UTF16LE = 2'd1;
  localparam logic [1:0] ENC_UTF16BE = 2'd2;

  // UTF-8 byte order mark matcher positions
  localparam logic [1:0] PFX_START = 2'd0;
  localparam logic [1:0] PFX_EF    = 2'd1;
  localparam logic [1:0] PFX_EFBB  = 2'd2;
  localparam logic [1:0] PFX_DONE  = 2'd3;

  // Byte and unit constants
  localparam logic [7:0]  BOM8_0      = 8'hEF;
  localparam logic [7:0]  BOM8_1      = 8'hBB;
  localparam logic [7:0]  BOM8_2      = 8'hBF;
  localparam logic [15:0] BOM16       = 16'hFEFF;
  localparam logic [15:0] LEAD_LO     = 16'hD800;
  localparam logic [15:0] LEAD_HI     = 16'hDBFF;
  localparam logic [15:0] TRAIL_LO    = 16'hDC00;
  localparam logic [15:0] TRAIL_HI    = 16'hDFFF;
  localparam logic [15:0] REPLACEMENT = 16'hFFFD;

  // Result queue geometry
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;
  localparam int Q_CW    = 3;

  // One result as it leaves the block
  typedef struct packed {
    logic [15:0] unit;
    logic        valid;
    logic        last;
  } result_t;

  // Up to three units produced by one byte
  typedef struct packed {
    logic [2:0][15:0] unit;
    logic [1:0]       cnt;
  } unit_list_t;

  function automatic unit_list_t push_unit(input unit_list_t l, input logic [15:0] v);
    unit_list_t r;
    r = l;
    if (l.cnt != 2'd3) begin
      r.unit[l.cnt] = v;
      r.cnt = l.cnt + 2'd1;
    end
    return r;
  endfunction

  function automatic logic is_lead(input logic [15:0] u);
    return (u >= LEAD_LO) && (u <= LEAD_HI);
  endfunction

  function automatic logic is_trail(input logic [15:0] u);
    return (u >= TRAIL_LO) && (u <= TRAIL_HI);
  endfunction

endpackage

@@ rtl/utf16_byte_stream_decoder.sv @@
// Latency: the first result of a byte is offered on the cycle after the byte is accepted,
//   when no earlier result is still waiting in the result queue.
// Throughput: one byte per cycle while each byte yields at most one result and out_stall
//   is low; a byte that yields two or three results can stall the input until the
//   four-entry result queue, draining one result per cycle while out_stall is low, holds at most one.
// Reset (rst, synchronous): encoding returns to UTF-8, message state and queue clear.
`include "assert_macros.svh"

module utf16_byte_stream_decoder
  import ubsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_write_en,
  input  logic [1:0]  cfg_write_data,
  // input bytes
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        is_last_byte,
  // output units
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] code_unit,
  output logic        unit_valid,
  output logic        is_last_unit
);

  // Registers
  logic [1:0]  encoding;
  logic [7:0]  held_byte;
  logic        byte_is_held;
  logic [15:0] held_lead_surrogate;
  logic        lead_is_held;
  logic        anything_emitted;
  logic [1:0]  prefix_position;

  result_t         queue [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_CW-1:0] fill;

  // Next values
  logic [7:0]  held_byte_next;
  logic        byte_is_held_next;
  logic [15:0] held_lead_surrogate_next;
  logic        lead_is_held_next;
  logic        anything_emitted_next;
  logic [1:0]  prefix_position_next;

  unit_list_t  lst;
  result_t     res [3];
  logic [1:0]  push_cnt;
  logic [15:0] pair;
  logic        odd_end;
  logic        in_accept;
  logic        out_accept;
  logic        big_endian;

  // Handshake: room for a worst-case byte (three results) is kept in reserve
  assign in_stall   = (fill > Q_CW'(Q_DEPTH - 3));
  assign in_accept  = in_valid && !in_stall;
  assign out_valid  = (fill != '0);
  assign out_accept = out_valid && !out_stall;
  assign big_endian = (encoding == ENC_UTF16BE);

  assign code_unit    = queue[rd_ptr].unit;
  assign unit_valid   = queue[rd_ptr].valid;
  assign is_last_unit = queue[rd_ptr].last;

  // Per-byte decode
  always_comb begin
    lst                      = '0;
    odd_end                  = 1'b0;
    pair                     = '0;
    held_byte_next           = held_byte;
    byte_is_held_next        = byte_is_held;
    held_lead_surrogate_next = held_lead_surrogate;
    lead_is_held_next        = lead_is_held;
    prefix_position_next     = prefix_position;

    if (encoding == ENC_UTF16LE || encoding == ENC_UTF16BE) begin
      // UTF-16: pair bytes, then surrogate handling
      if (byte_is_held) begin
        pair = big_endian ? {held_byte, data_byte} : {data_byte, held_byte};
        byte_is_held_next = 1'b0;
        held_byte_next    = '0;
        if (lead_is_held && is_trail(pair)) begin
          lead_is_held_next        = 1'b0;
          held_lead_surrogate_next = '0;
          lst = push_unit(lst, held_lead_surrogate);
          lst = push_unit(lst, pair);
        end else begin
          if (lead_is_held) begin
            lead_is_held_next        = 1'b0;
            held_lead_surrogate_next = '0;
            lst = push_unit(lst, REPLACEMENT);
          end
          priority if (!anything_emitted && lst.cnt == 2'd0 && pair == BOM16) begin
            // byte order mark before any output: dropped
          end else if (is_lead(pair)) begin
            held_lead_surrogate_next = pair;
            lead_is_held_next        = 1'b1;
          end else if (is_trail(pair)) begin
            lst = push_unit(lst, REPLACEMENT);
          end else begin
            lst = push_unit(lst, pair);
          end
        end
      end else if (is_last_byte) begin
        odd_end = 1'b1;
      end else begin
        held_byte_next    = data_byte;
        byte_is_held_next = 1'b1;
      end
      // end of message: flush a pending lead, then an odd byte
      if (is_last_byte) begin
        if (lead_is_held_next) begin
          lead_is_held_next = 1'b0;
          lst = push_unit(lst, REPLACEMENT);
        end
        if (odd_end) begin
          lst = push_unit(lst, REPLACEMENT);
        end
      end
    end else begin
      // UTF-8: pass through, dropping a complete leading EF BB BF
      unique case (prefix_position)
        PFX_START: begin
          if (data_byte == BOM8_0) begin
            prefix_position_next = PFX_EF;
          end else begin
            lst = push_unit(lst, {8'h00, data_byte});
            prefix_position_next = PFX_DONE;
          end
        end
        PFX_EF: begin
          if (data_byte == BOM8_1) begin
            prefix_position_next = PFX_EFBB;
          end else begin
            lst = push_unit(lst, {8'h00, BOM8_0});
            lst = push_unit(lst, {8'h00, data_byte});
            prefix_position_next = PFX_DONE;
          end
        end
        PFX_EFBB: begin
          if (data_byte != BOM8_2) begin
            lst = push_unit(lst, {8'h00, BOM8_0});
            lst = push_unit(lst, {8'h00, BOM8_1});
            lst = push_unit(lst, {8'h00, data_byte});
          end
          prefix_position_next = PFX_DONE;
        end
        default: begin
          lst = push_unit(lst, {8'h00, data_byte});
        end
      endcase
      // short prefix at end of message is emitted as data
      if (is_last_byte) begin
        if (prefix_position_next == PFX_EF) begin
          lst = push_unit(lst, {8'h00, BOM8_0});
        end else if (prefix_position_next == PFX_EFBB) begin
          lst = push_unit(lst, {8'h00, BOM8_0});
          lst = push_unit(lst, {8'h00, BOM8_1});
        end
      end
    end

    anything_emitted_next = anything_emitted || (lst.cnt != 2'd0);

    // Build queue entries; empty marker when the last byte gives nothing
    for (int i = 0; i < 3; i++) begin
      res[i].unit  = lst.unit[i];
      res[i].valid = 1'b1;
      res[i].last  = is_last_byte && (lst.cnt == 2'(i + 1));
    end
    push_cnt = lst.cnt;
    if (is_last_byte && lst.cnt == 2'd0) begin
      res[0].unit  = '0;
      res[0].valid = 1'b0;
      res[0].last  = 1'b1;
      push_cnt     = 2'd1;
    end

    // Message state returns to reset after the last byte
    if (is_last_byte) begin
      held_byte_next           = '0;
      byte_is_held_next        = 1'b0;
      held_lead_surrogate_next = '0;
      lead_is_held_next        = 1'b0;
      anything_emitted_next    = 1'b0;
      prefix_position_next     = PFX_START;
    end
  end

  // Control and message state
  always_ff @(posedge clk) begin
    if (rst) begin
      encoding            <= ENC_UTF8;
      held_byte           <= '0;
      byte_is_held        <= 1'b0;
      held_lead_surrogate <= '0;
      lead_is_held        <= 1'b0;
      anything_emitted    <= 1'b0;
      prefix_position     <= PFX_START;
      wr_ptr              <= '0;
      rd_ptr              <= '0;
      fill                <= '0;
    end else begin
      if (cfg_write_en) begin
        // new encoding restarts the message
        encoding            <= cfg_write_data;
        held_byte           <= '0;
        byte_is_held        <= 1'b0;
        held_lead_surrogate <= '0;
        lead_is_held        <= 1'b0;
        anything_emitted    <= 1'b0;
        prefix_position     <= PFX_START;
      end else if (in_accept) begin
        held_byte           <= held_byte_next;
        byte_is_held        <= byte_is_held_next;
        held_lead_surrogate <= held_lead_surrogate_next;
        lead_is_held        <= lead_is_held_next;
        anything_emitted    <= anything_emitted_next;
        prefix_position     <= prefix_position_next;
      end
      if (in_accept) begin
        wr_ptr <= wr_ptr + Q_AW'(push_cnt);
      end
      if (out_accept) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fill <= fill + (in_accept ? Q_CW'(push_cnt) : '0) - Q_CW'(out_accept);
    end
  end

  // Result queue payload
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (in_accept && 2'(i) < push_cnt) begin
        queue[wr_ptr + Q_AW'(i)] <= res[i];
      end
    end
  end

  // Assertions
  `ASSERT_CLK(a_fill_bound, fill <= Q_CW'(Q_DEPTH), "result queue overfilled")
  `ASSERT_CLK(a_last_clears, (in_accept && is_last_byte && !cfg_write_en) |=> (!byte_is_held && !lead_is_held && !anything_emitted && prefix_position == PFX_START), "message state not cleared after last byte")
  `ASSERT_CLK(a_no_spurious_out, (!out_valid && !in_accept) |=> !out_valid, "result appeared without an input byte")
  `ASSERT_CLK(a_held_byte_mode, byte_is_held |-> (encoding == ENC_UTF16LE || encoding == ENC_UTF16BE), "byte held outside UTF-16 mode")
  `ASSERT_CLK(a_lead_range, lead_is_held |-> is_lead(held_lead_surrogate), "held unit is not a lead surrogate")

endmodule
